// ===== sv/lfac_pkg.sv =====
package lfac_pkg;

  localparam int unsigned ADDR_W = 31;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  // positions of the index group carried with each classified access
  localparam int unsigned IX_SLOT   = 0;
  localparam int unsigned IX_RANK   = 1;
  localparam int unsigned IX_VICTIM = 2;
  localparam int unsigned IX_COUNT  = 3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              evict;
    logic [ADDR_W-1:0] evict_addr;
  } lfac_cls_t;

endpackage

// ===== sv/lfac_front.sv =====
module lfac_front import lfac_pkg::*; #(
  parameter int ENTRIES = 64,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OCC_W = $clog2(ENTRIES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ADDR_W-1:0]                   block_addr,
  input  logic [ENTRIES-1:0][ADDR_W-1:0]      dir_tag,
  input  logic [ENTRIES-1:0]                  dir_valid,
  input  logic [ENTRIES-1:0][IDX_W-1:0]       dir_rank,
  input  logic [OCC_W-1:0]                    occupied,
  input  logic [CAP_W-1:0]                    cap_limit,
  input  logic                                q_empty,
  output logic                                push,
  output lfac_cls_t                           cls,
  output logic [IX_COUNT-1:0][IDX_W-1:0]      idx
);

  localparam int CW = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic              held;
  logic [ADDR_W-1:0] addr;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] fill_oh;
  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      lim;
  logic               need_evict;
  logic [IDX_W-1:0]   oldest_rank;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   fill_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   victim_idx;
  logic [ADDR_W-1:0]  victim_tag;

  // classify only once the back end has written the previous access
  assign push     = held && q_empty;
  assign in_stall = held && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      addr <= block_addr;
    end
  end

  always_comb begin
    cap_ext = CW'(cap_limit);
    if (cap_ext == '0) begin
      lim = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      lim = CW'(ENTRIES);
    end else begin
      lim = cap_ext;
    end
  end

  assign oldest_rank = IDX_W'(occupied - OCC_W'(1));
  assign need_evict  = !(|match) && (CW'(occupied) >= lim);

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match[k]  = dir_valid[k] && (dir_tag[k] == addr);
      oldest[k] = dir_valid[k] && (dir_rank[k] == oldest_rank);
      free[k]   = !dir_valid[k] || (need_evict && oldest[k]);
    end
  end

  // lowest free slot
  assign fill_oh = free & (~free + ENTRIES'(1));

  always_comb begin
    hit_idx    = '0;
    fill_idx   = '0;
    hit_rank   = '0;
    victim_idx = '0;
    victim_tag = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (match[k]) begin
        hit_idx  = hit_idx | IDX_W'(k);
        hit_rank = hit_rank | dir_rank[k];
      end
      if (fill_oh[k]) begin
        fill_idx = fill_idx | IDX_W'(k);
      end
      if (oldest[k]) begin
        victim_idx = victim_idx | IDX_W'(k);
        victim_tag = victim_tag | dir_tag[k];
      end
    end
  end

  always_comb begin
    cls.addr           = addr;
    cls.hit            = |match;
    cls.evict          = need_evict;
    cls.evict_addr     = need_evict ? victim_tag : '0;
    idx[IX_SLOT]       = (|match) ? hit_idx : fill_idx;
    idx[IX_RANK]       = hit_rank;
    idx[IX_VICTIM]     = victim_idx;
  end

endmodule

// ===== sv/lfac_queue.sv =====
module lfac_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign empty = (count == 2'd0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/lfac_back.sv =====
module lfac_back import lfac_pkg::*; #(
  parameter int ENTRIES = 64,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OCC_W = $clog2(ENTRIES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  lfac_cls_t                      cls,
  input  logic [IX_COUNT-1:0][IDX_W-1:0] idx,
  output logic                           pop,
  output logic [ENTRIES-1:0][ADDR_W-1:0] dir_tag,
  output logic [ENTRIES-1:0]             dir_valid,
  output logic [ENTRIES-1:0][IDX_W-1:0]  dir_rank,
  output logic [OCC_W-1:0]               occupied,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic                           evict_valid,
  output logic [ADDR_W-1:0]              evict_addr,
  output logic [CNT_W-1:0]               hit_total,
  output logic [CNT_W-1:0]               miss_total
);

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt_next;

  logic [ENTRIES-1:0]            valid_next;
  logic [ENTRIES-1:0][IDX_W-1:0] rank_next;
  logic [ENTRIES-1:0]            fill;

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (cls.hit) begin
      if (hit_cnt != CNT_MAX) begin
        hit_cnt_next = hit_cnt + CNT_W'(1);
      end
    end else if (miss_cnt != CNT_MAX) begin
      miss_cnt_next = miss_cnt + CNT_W'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      valid_next[k] = dir_valid[k];
      rank_next[k]  = dir_rank[k];
      fill[k]       = 1'b0;
      if (cls.hit) begin
        // entries more recent than the touched one age by one
        if (dir_valid[k]) begin
          if (idx[IX_SLOT] == IDX_W'(k)) begin
            rank_next[k] = '0;
          end else if (dir_rank[k] < idx[IX_RANK]) begin
            rank_next[k] = dir_rank[k] + IDX_W'(1);
          end
        end
      end else if (idx[IX_SLOT] == IDX_W'(k)) begin
        fill[k]       = 1'b1;
        valid_next[k] = 1'b1;
        rank_next[k]  = '0;
      end else if (cls.evict && (idx[IX_VICTIM] == IDX_W'(k))) begin
        valid_next[k] = 1'b0;
        rank_next[k]  = '0;
      end else if (dir_valid[k]) begin
        rank_next[k] = dir_rank[k] + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_valid <= '0;
      dir_rank  <= '0;
      occupied  <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        dir_valid <= valid_next;
        dir_rank  <= rank_next;
        hit_cnt   <= hit_cnt_next;
        miss_cnt  <= miss_cnt_next;
        if (!cls.hit && !cls.evict) begin
          occupied <= occupied + OCC_W'(1);
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (pop && fill[k]) begin
        dir_tag[k] <= cls.addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hit         <= cls.hit;
      evict_valid <= cls.evict;
      evict_addr  <= cls.evict_addr;
      hit_total   <= hit_cnt_next;
      miss_total  <= miss_cnt_next;
    end
  end

endmodule

// ===== sv/lru_fully_associative_cache_core.sv =====
// channel   direction  handshake             payload
// in        in         in_valid / in_stall   block_addr
// out       out        out_valid / out_stall hit, evict_valid, evict_addr, hit_total, miss_total
// cfg       in         cfg_valid / cfg_ready capacity
//
// accesses are handled in two steps: a parallel tag compare and victim pick against the
// directory while the access sits in the front register, then a write of the new recency
// order by the back end; the next compare waits for that write. a beat taken while the
// previous access is still in the front register waits there until the queue has emptied.
// synchronous reset empties the directory, clears both counters and sets capacity to 64.
// a stalled result holds in the output register; one access waits in the queue and one in
// the front register before in_stall rises.
module lru_fully_associative_cache_core import lfac_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] block_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic              evict_valid,
  output logic [ADDR_W-1:0] evict_addr,
  output logic [CNT_W-1:0]  hit_total,
  output logic [CNT_W-1:0]  miss_total,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  capacity
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int QW    = $bits(lfac_cls_t) + IX_COUNT * IDX_W;

  logic [CAP_W-1:0] cap_limit;

  logic [ENTRIES-1:0][ADDR_W-1:0] dir_tag;
  logic [ENTRIES-1:0]             dir_valid;
  logic [ENTRIES-1:0][IDX_W-1:0]  dir_rank;
  logic [OCC_W-1:0]               occupied;

  logic                           push;
  logic                           pop;
  logic                           q_empty;
  lfac_cls_t                      f_cls;
  logic [IX_COUNT-1:0][IDX_W-1:0] f_idx;
  lfac_cls_t                      b_cls;
  logic [IX_COUNT-1:0][IDX_W-1:0] b_idx;
  logic [QW-1:0]                  q_wdata;
  logic [QW-1:0]                  q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_limit <= capacity;
    end
  end

  assign q_wdata        = {f_cls, f_idx};
  assign {b_cls, b_idx} = q_rdata;

  lfac_front #(.ENTRIES(ENTRIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .block_addr (block_addr),
    .dir_tag    (dir_tag),
    .dir_valid  (dir_valid),
    .dir_rank   (dir_rank),
    .occupied   (occupied),
    .cap_limit  (cap_limit),
    .q_empty    (q_empty),
    .push       (push),
    .cls        (f_cls),
    .idx        (f_idx)
  );

  lfac_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lfac_back #(.ENTRIES(ENTRIES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .cls         (b_cls),
    .idx         (b_idx),
    .pop         (pop),
    .dir_tag     (dir_tag),
    .dir_valid   (dir_valid),
    .dir_rank    (dir_rank),
    .occupied    (occupied),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .evict_valid (evict_valid),
    .evict_addr  (evict_addr),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
  );

endmodule

// ===== sv/lfac_checker.sv =====
module lfac_checker import lfac_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              hit,
  input logic              evict_valid,
  input logic [ADDR_W-1:0] evict_addr,
  input logic [CNT_W-1:0]  hit_total,
  input logic [CNT_W-1:0]  miss_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({hit, evict_valid, evict_addr, hit_total, miss_total}))
    else $error("result changed while stalled");

  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evict_valid))
    else $error("eviction reported on a hit");

  a_evict_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evict_valid |-> evict_addr == '0)
    else $error("evict address set with no eviction");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit ? (hit_total != '0) : (miss_total != '0)))
    else $error("counter of this access still zero");

endmodule

bind lru_fully_associative_cache_core lfac_checker u_chk (.*);
